// ===== hdl/emp_pkg.sv =====
// Shared types, constants and the division step for the edge midpoint block.
// Used by every module of the block and by its checker.
package emp_pkg;

  localparam int DivSteps  = 48;
  localparam int RemW      = 31;
  localparam int ScaleW    = 48;
  localparam int ScaleFrac = 16;
  localparam int ProjW     = 42;
  localparam int MagW      = 41;
  localparam int ChW       = 5;
  localparam int RedPos    = 10;
  localparam int GreenPos  = 5;

  localparam logic [MagW-1:0] MagClamp = 41'h100_0000_0000;

  localparam logic [7:0] ClipBehind = 8'h80;
  localparam logic [7:0] ClipLeft   = 8'h01;
  localparam logic [7:0] ClipRight  = 8'h02;
  localparam logic [7:0] ClipTop    = 8'h04;
  localparam logic [7:0] ClipBottom = 8'h08;

  typedef enum logic [2:0] {
    CfgNearDepth  = 3'd0,
    CfgPerspScale = 3'd1,
    CfgCenterX    = 3'd2,
    CfgCenterY    = 3'd3,
    CfgInvPersp   = 3'd4,
    CfgWindowX    = 3'd5,
    CfgWindowY    = 3'd6
  } emp_cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] first_view_x;
    logic signed [31:0] first_view_y;
    logic signed [31:0] first_view_z;
    logic [15:0]        first_color;
    logic [15:0]        first_tex_u;
    logic [15:0]        first_tex_v;
    logic signed [31:0] second_view_x;
    logic signed [31:0] second_view_y;
    logic signed [31:0] second_view_z;
    logic [15:0]        second_color;
    logic [15:0]        second_tex_u;
    logic [15:0]        second_tex_v;
  } emp_in_t;

  typedef struct packed {
    logic signed [31:0] mid_view_x;
    logic signed [31:0] mid_view_y;
    logic signed [31:0] mid_view_z;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic [31:0]        depth_recip;
    logic signed [7:0]  clip_code;
    logic [14:0]        mid_color;
    logic [15:0]        mid_tex_u;
    logic [15:0]        mid_tex_v;
  } emp_out_t;

  typedef struct packed {
    logic [30:0] near_depth;
    logic [31:0] persp_scale;
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] inv_persp;
    logic [63:0] window_x_bounds;
    logic [63:0] window_y_bounds;
  } emp_cfg_t;

  typedef struct packed {
    logic signed [31:0] mid_x;
    logic signed [31:0] mid_y;
    logic signed [31:0] mid_z;
    logic [14:0]        color;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
  } emp_mid_t;

  typedef struct packed {
    emp_mid_t          mid;
    logic              behind;
    logic [RemW-1:0]   rem;
    logic [ScaleW-1:0] quo;
  } emp_div_t;

  // One restoring step: shift in the next dividend bit, subtract the depth if it fits.
  function automatic emp_div_t emp_div_step(emp_div_t cur, logic nbit, int k);
    emp_div_t    nxt;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;
    nxt   = cur;
    trial = {cur.rem, nbit};
    diff  = trial - {1'b0, cur.mid.mid_z[RemW-1:0]};
    ge    = trial >= {1'b0, cur.mid.mid_z[RemW-1:0]};
    nxt.rem    = ge ? diff[RemW-1:0] : trial[RemW-1:0];
    nxt.quo[k] = ge;
    return nxt;
  endfunction

endpackage

// ===== hdl/edge_midpoint_project_clip.sv =====
// Edge midpoint with perspective projection and outcode.
// Stages: 1 entry stage, 48 divider stages at one quotient bit each, and 5 projection
// stages including the output register.
// Throughput: one item per clock; a stalled output holds every stage in place.
// Reset: synchronous, active low; clears all valid bits and the configuration registers.
// Depends on emp_pkg, emp_front, emp_divider, emp_project.
module edge_midpoint_project_clip (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  emp_pkg::emp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output emp_pkg::emp_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import emp_pkg::*;

  emp_cfg_t cfg_r;
  logic     advance;
  logic     mid_valid;
  emp_mid_t mid_data;
  logic     div_valid;
  emp_div_t div_data;

  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (emp_cfg_idx_t'(cfg_index))
        CfgNearDepth:  cfg_r.near_depth      <= cfg_data[30:0];
        CfgPerspScale: cfg_r.persp_scale     <= cfg_data[31:0];
        CfgCenterX:    cfg_r.center_x        <= cfg_data[31:0];
        CfgCenterY:    cfg_r.center_y        <= cfg_data[31:0];
        CfgInvPersp:   cfg_r.inv_persp       <= cfg_data[31:0];
        CfgWindowX:    cfg_r.window_x_bounds <= cfg_data;
        CfgWindowY:    cfg_r.window_y_bounds <= cfg_data;
        default: ;
      endcase
    end
  end

  emp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .mid_valid (mid_valid),
    .mid_data  (mid_data)
  );

  emp_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .cfg       (cfg_r),
    .mid_valid (mid_valid),
    .mid_data  (mid_data),
    .div_valid (div_valid),
    .div_data  (div_data)
  );

  emp_project u_project (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .cfg       (cfg_r),
    .div_valid (div_valid),
    .div_data  (div_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/emp_front.sv =====
// Entry stage: floor midpoints of view coordinates, colour channels and texture.
// Depends on emp_pkg.
module emp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             in_valid,
  input  emp_pkg::emp_in_t in_data,
  output logic             mid_valid,
  output emp_pkg::emp_mid_t mid_data
);
  import emp_pkg::*;

  logic     vld_r;
  emp_mid_t mid_r;
  emp_mid_t mid_nxt;

  logic [32:0] sum_x;
  logic [32:0] sum_y;
  logic [32:0] sum_z;
  logic [ChW:0] sum_r;
  logic [ChW:0] sum_g;
  logic [ChW:0] sum_b;
  logic [16:0] sum_u;
  logic [16:0] sum_v;

  always_comb begin
    sum_x = {in_data.first_view_x[31], in_data.first_view_x}
          + {in_data.second_view_x[31], in_data.second_view_x};
    sum_y = {in_data.first_view_y[31], in_data.first_view_y}
          + {in_data.second_view_y[31], in_data.second_view_y};
    sum_z = {in_data.first_view_z[31], in_data.first_view_z}
          + {in_data.second_view_z[31], in_data.second_view_z};
    sum_r = {1'b0, in_data.first_color[RedPos+ChW-1:RedPos]}
          + {1'b0, in_data.second_color[RedPos+ChW-1:RedPos]};
    sum_g = {1'b0, in_data.first_color[GreenPos+ChW-1:GreenPos]}
          + {1'b0, in_data.second_color[GreenPos+ChW-1:GreenPos]};
    sum_b = {1'b0, in_data.first_color[ChW-1:0]}
          + {1'b0, in_data.second_color[ChW-1:0]};
    sum_u = {1'b0, in_data.first_tex_u} + {1'b0, in_data.second_tex_u};
    sum_v = {1'b0, in_data.first_tex_v} + {1'b0, in_data.second_tex_v};
    mid_nxt.mid_x = sum_x[32:1];
    mid_nxt.mid_y = sum_y[32:1];
    mid_nxt.mid_z = sum_z[32:1];
    mid_nxt.color = {sum_r[ChW:1], sum_g[ChW:1], sum_b[ChW:1]};
    mid_nxt.tex_u = sum_u[16:1];
    mid_nxt.tex_v = sum_v[16:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid_valid = vld_r;
  assign mid_data  = mid_r;

endmodule

// ===== hdl/emp_divider.sv =====
// Pipelined restoring divider: scale = (persp_scale << 16) / depth, one quotient
// bit per stage, with the near-plane test taken at entry. Depends on emp_pkg.
module emp_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  emp_pkg::emp_cfg_t cfg,
  input  logic              mid_valid,
  input  emp_pkg::emp_mid_t mid_data,
  output logic              div_valid,
  output emp_pkg::emp_div_t div_data
);
  import emp_pkg::*;

  logic [DivSteps-1:0] vld_r;
  emp_div_t            div_r [DivSteps];
  emp_div_t            entry;
  logic [ScaleW-1:0]   dividend;

  always_comb begin
    dividend     = {cfg.persp_scale, {ScaleFrac{1'b0}}};
    entry.mid    = mid_data;
    entry.behind = $signed(mid_data.mid_z) <= $signed({1'b0, cfg.near_depth});
    entry.rem    = '0;
    entry.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[DivSteps-2:0], mid_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      div_r[0] <= emp_div_step(entry, dividend[DivSteps-1], DivSteps-1);
      for (int i = 1; i < DivSteps; i++) begin
        div_r[i] <= emp_div_step(div_r[i-1], dividend[DivSteps-1-i], DivSteps-1-i);
      end
    end
  end

  assign div_valid = vld_r[DivSteps-1];
  assign div_data  = div_r[DivSteps-1];

endmodule

// ===== hdl/emp_project.sv =====
// Projection back end: split products, rounding, clamp, centre offset,
// outcode and saturation into the output register. Depends on emp_pkg.
module emp_project (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  emp_pkg::emp_cfg_t cfg,
  input  logic              div_valid,
  input  emp_pkg::emp_div_t div_data,
  output logic              out_valid,
  output emp_pkg::emp_out_t out_data
);
  import emp_pkg::*;

  logic [4:0] vld_r;

  // stage 1: magnitudes and reciprocal partial products
  emp_mid_t          s1_mid_r;
  logic              s1_behind_r;
  logic [ScaleW-1:0] s1_scale_r;
  logic [31:0]       s1_mag_x_r, s1_mag_x_nxt;
  logic [31:0]       s1_mag_y_r, s1_mag_y_nxt;
  logic              s1_neg_x_r, s1_neg_y_r;
  logic [47:0]       s1_ooz_hi_r, s1_ooz_hi_nxt;
  logic [63:0]       s1_ooz_lo_r, s1_ooz_lo_nxt;

  // stage 2: projection partial products, saturated reciprocal
  emp_mid_t    s2_mid_r;
  logic        s2_behind_r;
  logic        s2_neg_x_r, s2_neg_y_r;
  logic [63:0] s2_px_h_r, s2_px_h_nxt;
  logic [47:0] s2_px_l_r, s2_px_l_nxt;
  logic [63:0] s2_py_h_r, s2_py_h_nxt;
  logic [47:0] s2_py_l_r, s2_py_l_nxt;
  logic [48:0] ooz_sum;
  logic [31:0] s2_ooz_r, s2_ooz_nxt;

  // stage 3: combined magnitudes
  emp_mid_t    s3_mid_r;
  logic        s3_behind_r;
  logic        s3_neg_x_r, s3_neg_y_r;
  logic [63:0] s3_qx_r, s3_qx_nxt;
  logic [63:0] s3_qy_r, s3_qy_nxt;
  logic [31:0] s3_ooz_r;

  // stage 4: clamped, signed and centred
  emp_mid_t          s4_mid_r;
  logic              s4_behind_r;
  logic [MagW-1:0]   qcx, qcy;
  logic [ProjW-1:0]  s4_xs_r, s4_xs_nxt;
  logic [ProjW-1:0]  s4_ys_r, s4_ys_nxt;
  logic [31:0]       s4_ooz_r;

  // stage 5: outcode and saturation
  logic signed [ProjW-1:0] xs, ys, left_e, right_e, top_e, bottom_e;
  logic [7:0]              code_x, code_y;
  emp_out_t                out_r, out_nxt;

  always_comb begin
    s1_mag_x_nxt  = div_data.mid.mid_x[31] ? 32'd0 - div_data.mid.mid_x : div_data.mid.mid_x;
    s1_mag_y_nxt  = div_data.mid.mid_y[31] ? 32'd0 - div_data.mid.mid_y : div_data.mid.mid_y;
    s1_ooz_hi_nxt = 48'(div_data.quo[47:32]) * 48'(cfg.inv_persp);
    s1_ooz_lo_nxt = 64'(div_data.quo[31:0]) * 64'(cfg.inv_persp);
  end

  always_comb begin
    s2_px_h_nxt = 64'(s1_mag_x_r) * 64'(s1_scale_r[47:16]);
    s2_px_l_nxt = 48'(s1_mag_x_r) * 48'(s1_scale_r[15:0]);
    s2_py_h_nxt = 64'(s1_mag_y_r) * 64'(s1_scale_r[47:16]);
    s2_py_l_nxt = 48'(s1_mag_y_r) * 48'(s1_scale_r[15:0]);
    ooz_sum     = 49'(s1_ooz_hi_r) + 49'(s1_ooz_lo_r[63:32]);
    s2_ooz_nxt  = (|ooz_sum[48:32]) ? 32'hFFFF_FFFF : ooz_sum[31:0];
  end

  always_comb begin
    s3_qx_nxt = s2_px_h_r + 64'(s2_px_l_r[47:16])
              + 64'(s2_neg_x_r && (s2_px_l_r[15:0] != 16'd0));
    s3_qy_nxt = s2_py_h_r + 64'(s2_py_l_r[47:16])
              + 64'(s2_neg_y_r && (s2_py_l_r[15:0] != 16'd0));
  end

  always_comb begin
    qcx = (s3_qx_r > 64'(MagClamp)) ? MagClamp : s3_qx_r[MagW-1:0];
    qcy = (s3_qy_r > 64'(MagClamp)) ? MagClamp : s3_qy_r[MagW-1:0];
    s4_xs_nxt = s3_neg_x_r ? ProjW'(cfg.center_x) - ProjW'(qcx)
                           : ProjW'(cfg.center_x) + ProjW'(qcx);
    s4_ys_nxt = s3_neg_y_r ? ProjW'(cfg.center_y) - ProjW'(qcy)
                           : ProjW'(cfg.center_y) + ProjW'(qcy);
  end

  always_comb begin
    xs       = $signed(s4_xs_r);
    ys       = $signed(s4_ys_r);
    left_e   = ProjW'($signed(cfg.window_x_bounds[31:0]));
    right_e  = ProjW'($signed(cfg.window_x_bounds[63:32]));
    top_e    = ProjW'($signed(cfg.window_y_bounds[31:0]));
    bottom_e = ProjW'($signed(cfg.window_y_bounds[63:32]));
    priority if (xs < left_e) begin
      code_x = ClipLeft;
    end else if (xs > right_e) begin
      code_x = ClipRight;
    end else begin
      code_x = 8'd0;
    end
    priority if (ys < top_e) begin
      code_y = ClipTop;
    end else if (ys > bottom_e) begin
      code_y = ClipBottom;
    end else begin
      code_y = 8'd0;
    end
    out_nxt.mid_view_x = s4_mid_r.mid_x;
    out_nxt.mid_view_y = s4_mid_r.mid_y;
    out_nxt.mid_view_z = s4_mid_r.mid_z;
    out_nxt.mid_color  = s4_mid_r.color;
    out_nxt.mid_tex_u  = s4_mid_r.tex_u;
    out_nxt.mid_tex_v  = s4_mid_r.tex_v;
    if (s4_behind_r) begin
      out_nxt.screen_x    = '0;
      out_nxt.screen_y    = '0;
      out_nxt.depth_recip = '0;
      out_nxt.clip_code   = ClipBehind;
    end else begin
      if ((&s4_xs_r[ProjW-1:31]) || !(|s4_xs_r[ProjW-1:31])) begin
        out_nxt.screen_x = s4_xs_r[31:0];
      end else begin
        out_nxt.screen_x = s4_xs_r[ProjW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      if ((&s4_ys_r[ProjW-1:31]) || !(|s4_ys_r[ProjW-1:31])) begin
        out_nxt.screen_y = s4_ys_r[31:0];
      end else begin
        out_nxt.screen_y = s4_ys_r[ProjW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      out_nxt.depth_recip = s4_ooz_r;
      out_nxt.clip_code   = code_x | code_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[3:0], div_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mid_r    <= div_data.mid;
      s1_behind_r <= div_data.behind;
      s1_scale_r  <= div_data.quo;
      s1_mag_x_r  <= s1_mag_x_nxt;
      s1_mag_y_r  <= s1_mag_y_nxt;
      s1_neg_x_r  <= div_data.mid.mid_x[31];
      s1_neg_y_r  <= div_data.mid.mid_y[31];
      s1_ooz_hi_r <= s1_ooz_hi_nxt;
      s1_ooz_lo_r <= s1_ooz_lo_nxt;

      s2_mid_r    <= s1_mid_r;
      s2_behind_r <= s1_behind_r;
      s2_neg_x_r  <= s1_neg_x_r;
      s2_neg_y_r  <= s1_neg_y_r;
      s2_px_h_r   <= s2_px_h_nxt;
      s2_px_l_r   <= s2_px_l_nxt;
      s2_py_h_r   <= s2_py_h_nxt;
      s2_py_l_r   <= s2_py_l_nxt;
      s2_ooz_r    <= s2_ooz_nxt;

      s3_mid_r    <= s2_mid_r;
      s3_behind_r <= s2_behind_r;
      s3_neg_x_r  <= s2_neg_x_r;
      s3_neg_y_r  <= s2_neg_y_r;
      s3_qx_r     <= s3_qx_nxt;
      s3_qy_r     <= s3_qy_nxt;
      s3_ooz_r    <= s2_ooz_r;

      s4_mid_r    <= s3_mid_r;
      s4_behind_r <= s3_behind_r;
      s4_xs_r     <= s4_xs_nxt;
      s4_ys_r     <= s4_ys_nxt;
      s4_ooz_r    <= s3_ooz_r;

      out_r       <= out_nxt;
    end
  end

  assign out_valid = vld_r[4];
  assign out_data  = out_r;

endmodule

// ===== hdl/emp_check.sv =====
// Port-level checker for edge_midpoint_project_clip, attached by bind.
// Depends on emp_pkg.
module emp_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input emp_pkg::emp_out_t out_data,
  input logic              cfg_valid,
  input logic              cfg_ready
);
  import emp_pkg::*;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.clip_code == ClipBehind) |->
      (out_data.screen_x == 0) && (out_data.screen_y == 0) && (out_data.depth_recip == 0))
    else $error("behind result carries screen fields");

endmodule

bind edge_midpoint_project_clip emp_check u_emp_check (.*);
